[rtl/core/assert_macros.svh]
// assertion macros used by the flow hash top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define FTH_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("flow hash check failed");

// next-cycle implication, clocked on clk, off during reset
`define FTH_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("flow hash check failed");

`endif

[rtl/core/fth_pkg.sv]
// package with types, codes and the toeplitz key for the flow tuple hash
package fth_pkg;

    localparam int KEY_BYTES       = 40;
    localparam int KEY_TABLE_BYTES = 64;
    localparam int MAX_TUPLE_BYTES = 36;
    localparam int TUPLE_BITS      = 8 * MAX_TUPLE_BYTES;
    localparam int CNT_W           = $clog2(MAX_TUPLE_BYTES + 1);
    localparam int KIDX_W          = $clog2(KEY_TABLE_BYTES) + 1;

    localparam logic [31:0] CRC_POLY    = 32'h82f63b78;
    localparam logic [31:0] CRC_INIT    = 32'hffffffff;
    localparam logic [31:0] CRC_XOROUT  = 32'hffffffff;

    localparam logic [CNT_W-1:0] LEN_V4_ADDR = CNT_W'(8);
    localparam logic [CNT_W-1:0] LEN_V6_ADDR = CNT_W'(32);
    localparam logic [CNT_W-1:0] LEN_PORTS   = CNT_W'(4);

    localparam logic [1:0] ALG_TOEPLITZ = 2'd0;
    localparam logic [1:0] ALG_XOR      = 2'd1;
    localparam logic [1:0] ALG_CRC32C   = 2'd2;
    localparam logic [1:0] ALG_RESET    = ALG_CRC32C;

    localparam logic MODE_FOUR_TUPLE = 1'b0;
    localparam logic MODE_ADDR_ONLY  = 1'b1;
    localparam logic MODE_RESET      = MODE_FOUR_TUPLE;

    localparam logic REG_HASH_ALG   = 1'b0;
    localparam logic REG_TUPLE_MODE = 1'b1;

    localparam logic [7:0] KEY_TABLE [KEY_TABLE_BYTES] = '{
        8'h6d, 8'h5a, 8'h56, 8'hda, 8'h25, 8'h5b, 8'h0e, 8'hc2, 8'h41, 8'h67,
        8'h25, 8'h3d, 8'h43, 8'ha3, 8'h8f, 8'hb0, 8'hd0, 8'hca, 8'h2b, 8'hcb,
        8'hae, 8'h7b, 8'h30, 8'hb4, 8'h77, 8'hcb, 8'h2d, 8'ha3, 8'h80, 8'h30,
        8'hf2, 8'h0c, 8'h6a, 8'h42, 8'hb7, 8'h3b, 8'hbe, 8'hac, 8'h01, 8'hfa,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FINISH
    } fth_state_t;

    typedef struct packed {
        logic is_ipv6;
        logic [63:0] src_addr_hi;
        logic [63:0] src_addr_lo;
        logic [63:0] dst_addr_hi;
        logic [63:0] dst_addr_lo;
        logic [15:0] sport;
        logic [15:0] dport;
    } fth_tuple_t;

    typedef struct packed {
        logic load;
        logic step;
        logic publish;
    } fth_cmd_t;

    typedef struct packed {
        logic last_byte;
        logic out_busy;
    } fth_sts_t;

    function automatic logic [7:0] key_byte(input logic [KIDX_W-1:0] idx);
        logic [7:0] kb;
        kb = 8'h00;
        if (idx < KIDX_W'(KEY_BYTES))
            kb = KEY_TABLE[idx[KIDX_W-2:0]];
        return kb;
    endfunction

endpackage

[rtl/core/fth_ctrl.sv]
// controller state machine for the flow tuple hash
module fth_ctrl
    import fth_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  fth_sts_t sts,
    output fth_cmd_t cmd
);

    fth_state_t state_reg;
    fth_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (sts.last_byte)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!sts.out_busy)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready    = 1'b0;
        cmd.load    = 1'b0;
        cmd.step    = 1'b0;
        cmd.publish = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_RUN:
                cmd.step = 1'b1;
            ST_FINISH:
                cmd.publish = !sts.out_busy;
            default:
                in_ready = 1'b0;
        endcase
    end

endmodule

[rtl/core/fth_datapath.sv]
// byte-serial datapath: tuple packer, toeplitz, xor and crc32c engines, output register
module fth_datapath
    import fth_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [1:0]  cfg_wdata,
    input  fth_tuple_t  tuple,
    input  fth_cmd_t    cmd,
    output fth_sts_t    sts,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] flow_hash
);

    logic [1:0]            hash_alg_reg;
    logic                  tuple_mode_reg;
    logic [TUPLE_BITS-1:0] buf_reg;
    logic [TUPLE_BITS-1:0] buf_next;
    logic [CNT_W-1:0]      idx_reg;
    logic [CNT_W-1:0]      idx_next;
    logic [CNT_W-1:0]      len_reg;
    logic [CNT_W-1:0]      len_next;
    logic [31:0]           win_reg;
    logic [31:0]           win_next;
    logic [31:0]           toep_reg;
    logic [31:0]           toep_next;
    logic [7:0]            xor_reg;
    logic [7:0]            xor_next;
    logic [31:0]           crc_reg;
    logic [31:0]           crc_next;
    logic [31:0]           hash_reg;
    logic [31:0]           hash_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [7:0]            cur_byte;
    logic [7:0]            kb;
    logic [39:0]           win_ext;
    logic [31:0]           toep_step;
    logic [31:0]           crc_step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_alg_reg   <= ALG_RESET;
            tuple_mode_reg <= MODE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_HASH_ALG:   hash_alg_reg   <= cfg_wdata;
                REG_TUPLE_MODE: tuple_mode_reg <= cfg_wdata[0];
                default:        hash_alg_reg   <= hash_alg_reg;
            endcase
        end
    end

    assign cur_byte = buf_reg[TUPLE_BITS-1 -: 8];
    assign kb       = key_byte(KIDX_W'(idx_reg) + KIDX_W'(4));
    assign win_ext  = {win_reg, kb};

    // toeplitz: msb first, window slides one key bit per data bit
    always_comb
    begin
        toep_step = toep_reg;
        for (int b = 0; b < 8; b++)
        begin
            if (cur_byte[7-b])
                toep_step = toep_step ^ win_ext[39-b -: 32];
        end
    end

    // reflected crc32c over one byte
    always_comb
    begin
        crc_step = crc_reg ^ {24'h000000, cur_byte};
        for (int b = 0; b < 8; b++)
        begin
            if (crc_step[0])
                crc_step = (crc_step >> 1) ^ CRC_POLY;
            else
                crc_step = crc_step >> 1;
        end
    end

    always_comb
    begin
        buf_next  = buf_reg;
        idx_next  = idx_reg;
        len_next  = len_reg;
        win_next  = win_reg;
        toep_next = toep_reg;
        xor_next  = xor_reg;
        crc_next  = crc_reg;
        if (cmd.load)
        begin
            if (tuple.is_ipv6)
                buf_next = {tuple.src_addr_hi, tuple.src_addr_lo, tuple.dst_addr_hi,
                            tuple.dst_addr_lo, tuple.sport, tuple.dport};
            else
                buf_next = {tuple.src_addr_lo[31:0], tuple.dst_addr_lo[31:0],
                            tuple.sport, tuple.dport, {(TUPLE_BITS-96){1'b0}}};
            len_next  = (tuple.is_ipv6 ? LEN_V6_ADDR : LEN_V4_ADDR)
                      + ((tuple_mode_reg == MODE_FOUR_TUPLE) ? LEN_PORTS : '0);
            idx_next  = '0;
            win_next  = {key_byte(KIDX_W'(0)), key_byte(KIDX_W'(1)),
                         key_byte(KIDX_W'(2)), key_byte(KIDX_W'(3))};
            toep_next = '0;
            xor_next  = '0;
            crc_next  = CRC_INIT;
        end
        else if (cmd.step)
        begin
            buf_next  = {buf_reg[TUPLE_BITS-9:0], 8'h00};
            idx_next  = idx_reg + CNT_W'(1);
            win_next  = win_ext[31:0];
            toep_next = toep_step;
            crc_next  = crc_step;
            if (idx_reg < {2'b00, len_reg[CNT_W-1:2]})
                xor_next = xor_reg ^ cur_byte;
        end
    end

    always_comb
    begin
        hash_next = hash_reg;
        if (cmd.publish)
        begin
            unique case (hash_alg_reg)
                ALG_TOEPLITZ: hash_next = toep_reg;
                ALG_XOR:      hash_next = {24'h000000, xor_reg};
                ALG_CRC32C:   hash_next = crc_reg ^ CRC_XOROUT;
                default:      hash_next = '0;
            endcase
        end
    end

    assign out_valid_next = cmd.publish ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk)
    begin
        buf_reg  <= buf_next;
        idx_reg  <= idx_next;
        len_reg  <= len_next;
        win_reg  <= win_next;
        toep_reg <= toep_next;
        xor_reg  <= xor_next;
        crc_reg  <= crc_next;
        hash_reg <= hash_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    assign sts.last_byte = (idx_reg == len_reg - CNT_W'(1));
    assign sts.out_busy  = out_valid_reg && !out_ready;
    assign out_valid     = out_valid_reg;
    assign flow_hash     = hash_reg;

endmodule

[rtl/core/flow_tuple_hash_unit.sv]
// top level of the flow tuple hash
//
//   channel   dir  handshake                      payload
//   s_axis    in   s_axis_tvalid/s_axis_tready    tdata: tuple fields, tuser: is_ipv6
//   m_axis    out  m_axis_tvalid/m_axis_tready    tdata: flow_hash
//   cfg       in   cfg_we                         cfg_index, cfg_wdata
//
// one tuple takes len byte steps: len = 8/12 (ipv4) or 32/36 (ipv6) bytes,
// as the hash engines take one byte per cycle, plus a load and a publish step
// rst_n clears the state machine, output valid and the config registers
// (algorithm crc32c, four-tuple mode)
// the next tuple is taken while a result waits in the output register;
// a stalled output holds the finished hash in the publish state
`include "assert_macros.svh"

module flow_tuple_hash_unit
    import fth_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // src_addr_hi, src_addr_lo, dst_addr_hi, dst_addr_lo, source port, destination port
    input  logic [287:0] s_axis_tdata,
    // is_ipv6
    input  logic [0:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // flow_hash
    output logic [31:0]  m_axis_tdata,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [1:0]   cfg_wdata
);

    fth_tuple_t tuple;
    fth_cmd_t   cmd;
    fth_sts_t   sts;

    assign tuple.is_ipv6     = s_axis_tuser[0];
    assign tuple.src_addr_hi = s_axis_tdata[63:0];
    assign tuple.src_addr_lo = s_axis_tdata[127:64];
    assign tuple.dst_addr_hi = s_axis_tdata[191:128];
    assign tuple.dst_addr_lo = s_axis_tdata[255:192];
    assign tuple.sport       = s_axis_tdata[271:256];
    assign tuple.dport       = s_axis_tdata[287:272];

    fth_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    fth_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .tuple     (tuple),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .flow_hash (m_axis_tdata)
    );

    `FTH_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `FTH_ASSERT_NEXT(a_publish_sets_valid, cmd.publish, m_axis_tvalid)
    `FTH_ASSERT_NOW(a_publish_no_overwrite, cmd.publish, !(m_axis_tvalid && !m_axis_tready))
    `FTH_ASSERT_NOW(a_one_command, 1'b1, $onehot0({cmd.load, cmd.step, cmd.publish}))

endmodule
